// ===== hdl/force_press_toggle_detector_defines.svh =====
// Assertion macros for the force press toggle detector checker.
// No dependencies; include by bare file name.
`ifndef FORCE_PRESS_TOGGLE_DETECTOR_DEFINES_SVH
`define FORCE_PRESS_TOGGLE_DETECTOR_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted
`define FPTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define FPTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fptd_pkg.sv =====
// Package for the force press toggle detector: widths, register map, reset values, queue depth.
// No dependencies.
package fptd_pkg;

    // Threshold and register widths
    localparam int THR_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 1;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELTA_THRESHOLD = 1'b0,
        CFG_OFFSET_PERIOD   = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] DELTA_RESET  = 16'd1000;
    localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd100;

    // Queue between threshold pipeline and state update
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== hdl/fptd_queue.sv =====
// Short flop-based item queue between the threshold pipeline and the state update.
// Depends on fptd_pkg (depth constants).
module fptd_queue
    import fptd_pkg::*;
#(
    parameter int W = 28
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [W-1:0]           data_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   push;
    logic                   pop;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hdl/fptd_front.sv =====
// Front part: accepts samples and works out the threshold in a three-stage pipeline
// (numerator multiply, reciprocal multiply in two halves, then sum and shift).
// Depends on fptd_pkg.
module fptd_front
    import fptd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CFG_W-1:0]       delta,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic [THR_W-1:0]       out_threshold
);

    localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
    localparam int DIVISOR    = 10 * FULL_SCALE;
    localparam int MULT_W     = $clog2(DIVISOR + 1);
    localparam int NUM_W      = THR_W + MULT_W;
    localparam int SHIFT      = NUM_W + MULT_W;
    localparam int RECIP_W    = NUM_W + 1;
    localparam int LO_W       = RECIP_W / 2;
    localparam int HI_W       = RECIP_W - LO_W;
    localparam int PLO_W      = NUM_W + LO_W;
    localparam int PHI_W      = NUM_W + HI_W;
    localparam int PROD_W     = NUM_W + RECIP_W;
    localparam int STAGES     = 3;

    // Reciprocal of the divisor rounded up; exact for every numerator below 2^NUM_W
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
    localparam logic [LO_W-1:0]    RECIP_LO = RECIP[LO_W-1:0];
    localparam logic [HI_W-1:0]    RECIP_HI = RECIP[RECIP_W-1:LO_W];

    logic [STAGES-1:0]      valid_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [PLO_W-1:0]       plo_reg;
    logic [PHI_W-1:0]       phi_reg;
    logic [THR_W-1:0]       thr_reg;
    logic [SAMPLE_BITS-1:0] smp_reg [0:STAGES-1];
    logic [MULT_W-1:0]      scale;
    logic [NUM_W-1:0]       num_next;
    logic [PLO_W-1:0]       plo_next;
    logic [PHI_W-1:0]       phi_next;
    logic [PROD_W-1:0]      prod;
    logic                   advance;

    // Stall the whole pipeline only when the last stage cannot leave
    assign advance       = !valid_reg[STAGES-1] || out_ready;
    assign in_ready      = advance;
    assign out_valid     = valid_reg[STAGES-1];
    assign out_sample    = smp_reg[STAGES-1];
    assign out_threshold = thr_reg;

    // Numerator: delta * (full scale + 9 * sample)
    assign scale    = MULT_W'(FULL_SCALE) + (MULT_W'(sample) << 3) + MULT_W'(sample);
    assign num_next = NUM_W'(delta) * NUM_W'(scale);

    // Multiply by the reciprocal, low and high halves side by side
    assign plo_next = PLO_W'(num_reg) * PLO_W'(RECIP_LO);
    assign phi_next = PHI_W'(num_reg) * PHI_W'(RECIP_HI);

    // Recombine the halves; the quotient sits above the shift
    assign prod = (PROD_W'(phi_reg) << LO_W) + PROD_W'(plo_reg);

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg    <= num_next;
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            thr_reg    <= prod[SHIFT +: THR_W];
            smp_reg[0] <= sample;
            for (int i = 1; i < STAGES; i++)
            begin
                smp_reg[i] <= smp_reg[i-1];
            end
        end
    end

endmodule

// ===== hdl/fptd_back.sv =====
// Back part: press and toggle state update, offset reload and the result register.
// Depends on fptd_pkg.
module fptd_back
    import fptd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CFG_W-1:0]       offset_period,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic [THR_W-1:0]       in_threshold,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   closing,
    output logic                   pressed,
    output logic                   below_threshold,
    output logic [THR_W-1:0]       threshold
);

    localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;

    logic                   seeded_reg,    seeded_next;
    logic [SAMPLE_BITS-1:0] offset_reg,    offset_next;
    logic [CFG_W-1:0]       count_reg,     count_next;
    logic                   armed_reg,     armed_next;
    logic                   flag_reg,      flag_next;
    logic                   action_reg,    action_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   below_reg,     below_next;
    logic [THR_W-1:0]       thr_reg,       thr_next;
    logic                   pop;
    logic signed [CMP_W-1:0] drop;
    logic signed [CMP_W-1:0] thr_s;
    logic [CFG_W-1:0]       count_inc;

    assign pop       = in_valid && (!out_valid_reg || out_ready);
    assign in_ready  = !out_valid_reg || out_ready;
    assign drop      = $signed(CMP_W'(offset_reg)) - $signed(CMP_W'(in_sample));
    assign thr_s     = $signed(CMP_W'(in_threshold));
    assign count_inc = count_reg + 1'b1;

    assign out_valid       = out_valid_reg;
    assign closing         = action_reg;
    assign pressed         = flag_reg;
    assign below_threshold = below_reg;
    assign threshold       = thr_reg;

    // Work out the next state for a popped item
    always_comb
    begin
        seeded_next    = seeded_reg;
        offset_next    = offset_reg;
        count_next     = count_reg;
        armed_next     = armed_reg;
        flag_next      = flag_reg;
        action_next    = action_reg;
        below_next     = below_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (pop)
        begin
            out_valid_next = 1'b1;
            if (!seeded_reg)
            begin
                // First item only seeds the offset
                offset_next = in_sample;
                count_next  = '0;
                seeded_next = 1'b1;
                below_next  = 1'b0;
                thr_next    = '0;
            end
            else
            begin
                thr_next   = in_threshold;
                below_next = (CMP_W'(in_sample) < CMP_W'(in_threshold));

                // Re-arm on a small drop, fire on a large one
                if (!armed_reg)
                begin
                    if (drop < thr_s)
                    begin
                        armed_next = 1'b1;
                        flag_next  = 1'b0;
                    end
                end
                else if (!flag_reg)
                begin
                    if (drop > thr_s)
                    begin
                        flag_next  = 1'b1;
                        armed_next = 1'b0;
                    end
                end

                // Reload the offset once per period
                if (count_inc >= offset_period)
                begin
                    offset_next = in_sample;
                    count_next  = '0;
                end
                else
                begin
                    count_next = count_inc;
                end

                // Toggle the action on a new press
                if (flag_next && !flag_reg)
                begin
                    action_next = !action_reg;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg    <= 1'b0;
            offset_reg    <= '0;
            count_reg     <= '0;
            armed_reg     <= 1'b1;
            flag_reg      <= 1'b0;
            action_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seeded_reg    <= seeded_next;
            offset_reg    <= offset_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
            flag_reg      <= flag_next;
            action_reg    <= action_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        below_reg <= below_next;
        thr_reg   <= thr_next;
    end

endmodule

// ===== hdl/force_press_toggle_detector.sv =====
// Top level of the force press toggle detector: configuration registers and the
// front pipeline, item queue and back state update. Depends on fptd_pkg and the fptd_* modules.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid/in_ready   | sample
//  out     | out_valid/out_ready | closing, pressed, below_threshold, threshold
//  cfg     | cfg_wr_en           | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; from acceptance to result an item
// passes the 3-stage threshold pipeline (multiply, reciprocal multiply, sum), one queue slot
// and the result register.
// Asynchronous active-low reset resets all control state and loads the register defaults.
// A stalled result holds in the output register; the queue lets the pipeline keep
// filling until it is full, and only then is in_ready dropped.
module force_press_toggle_detector
    import fptd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   closing,
    output logic                   pressed,
    output logic                   below_threshold,
    output logic [THR_W-1:0]       threshold,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int ITEM_W = SAMPLE_BITS + THR_W;

    logic [CFG_W-1:0]       delta_reg;
    logic [CFG_W-1:0]       period_reg;
    logic                   fr_valid;
    logic                   fr_ready;
    logic [SAMPLE_BITS-1:0] fr_sample;
    logic [THR_W-1:0]       fr_thr;
    logic                   bk_valid;
    logic                   bk_ready;
    logic [ITEM_W-1:0]      bk_data;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg  <= DELTA_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DELTA_THRESHOLD: delta_reg  <= cfg_data;
                CFG_OFFSET_PERIOD:   period_reg <= cfg_data;
            endcase
        end
    end

    fptd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .delta         (delta_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_sample    (fr_sample),
        .out_threshold (fr_thr)
    );

    fptd_queue #(
        .W (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   ({fr_sample, fr_thr}),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_data)
    );

    fptd_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .offset_period   (period_reg),
        .in_valid        (bk_valid),
        .in_ready        (bk_ready),
        .in_sample       (bk_data[ITEM_W-1:THR_W]),
        .in_threshold    (bk_data[THR_W-1:0]),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .closing         (closing),
        .pressed         (pressed),
        .below_threshold (below_threshold),
        .threshold       (threshold)
    );

endmodule

// ===== hdl/fptd_checker.sv =====
// Port-level checker for the force press toggle detector, bound to the top level.
// Depends on fptd_pkg and force_press_toggle_detector_defines.svh.
`include "force_press_toggle_detector_defines.svh"

module fptd_checker
    import fptd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic             closing,
    input logic             pressed,
    input logic             below_threshold,
    input logic [THR_W-1:0] threshold
);

    // A stalled result holds
    `FPTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({closing, pressed, below_threshold, threshold}), "result changed while stalled")

    // Below threshold needs a non-zero threshold
    `FPTD_ASSERT_NOW(a_below_nonzero, clk, rst_n, out_valid && below_threshold, threshold != '0, "below flag with zero threshold")

    // The action only changes together with a press
    `FPTD_ASSERT_NOW(a_toggle_needs_press, clk, rst_n, closing != $past(closing), pressed, "action toggled without a press")

    // A new press always toggles the action
    `FPTD_ASSERT_NOW(a_press_toggles, clk, rst_n, $rose(pressed), closing != $past(closing), "press did not toggle the action")

endmodule

bind force_press_toggle_detector fptd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .closing         (closing),
    .pressed         (pressed),
    .below_threshold (below_threshold),
    .threshold       (threshold)
);
